@@ rtl/core/cspc_pkg.sv @@
// Shared constants, types and helper functions of the clip-space polygon clipper.
package cspc_pkg;

   localparam int MAX_VERTS = 32;
   localparam int BANK      = MAX_VERTS + 8;
   localparam int PASS_CAP  = MAX_VERTS + 5;
   localparam int NUM_ATTR  = 8;
   localparam int ATTR_W    = 32;
   localparam int VTX_W     = NUM_ATTR * ATTR_W;
   localparam int RAM_DEPTH = 2 * BANK;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int CNT_W     = $clog2(PASS_CAP + 1);
   localparam int KSEL_W    = $clog2(NUM_ATTR);
   localparam int NEAR_W    = 17;
   localparam int DIST_W    = ATTR_W + 2;
   localparam int DIFF_W    = DIST_W + 1;
   localparam int FRAC_W    = 30;
   localparam int T_W       = FRAC_W + 1;
   localparam int OUT_W     = 5 * ATTR_W;

   localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(3277);

   // attribute slots within one stored vertex word
   localparam int ATTR_CX = 0;
   localparam int ATTR_CY = 1;
   localparam int ATTR_CW = 2;
   localparam int ATTR_EX = 3;

   typedef enum logic [2:0] {
      PLANE_NEAR = 3'd0,
      PLANE_XPOS = 3'd1,
      PLANE_XNEG = 3'd2,
      PLANE_YPOS = 3'd3,
      PLANE_YNEG = 3'd4
   } plane_type;

   // signed distance of a vertex to one clip plane, exact
   function automatic logic signed [DIST_W-1:0] plane_dist(
      input plane_type                p,
      input logic [VTX_W-1:0]         v,
      input logic [NEAR_W-1:0]        nr
   );
      logic signed [DIST_W-1:0] x;
      logic signed [DIST_W-1:0] y;
      logic signed [DIST_W-1:0] w;
      logic signed [DIST_W-1:0] d;
      x = DIST_W'($signed(v[ATTR_CX*ATTR_W +: ATTR_W]));
      y = DIST_W'($signed(v[ATTR_CY*ATTR_W +: ATTR_W]));
      w = DIST_W'($signed(v[ATTR_CW*ATTR_W +: ATTR_W]));
      case (p)
         PLANE_NEAR: d = w - $signed({{(DIST_W-NEAR_W){1'b0}}, nr});
         PLANE_XPOS: d = w - x;
         PLANE_XNEG: d = w + x;
         PLANE_YPOS: d = w - y;
         default:    d = w + y;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/core/cspc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cspc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/cspc_div.sv @@
// Restoring divider giving the Q1.30 crossing fraction, one bit per cycle.
module cspc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cspc_pkg::DIFF_W-1:0]  num,
   input  logic [cspc_pkg::DIFF_W-1:0]  den,
   output logic                         done,
   output logic [cspc_pkg::T_W-1:0]     quot
);
   import cspc_pkg::*;

   localparam int REM_W  = DIFF_W + 1;
   localparam int STEP_W = $clog2(T_W);

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [DIFF_W-1:0]   den_ff;
   logic [T_W-1:0]      quot_ff;
   logic                ge_in;
   logic [REM_W-1:0]    rem_in;

   // compare and subtract for the current quotient bit
   always_comb begin
      ge_in  = rem_ff >= REM_W'(den_ff);
      rem_in = ge_in ? rem_ff - REM_W'(den_ff) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(T_W - 1);
            rem_ff  <= REM_W'(num);
            den_ff  <= den;
            quot_ff <= '0;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[T_W-2:0], ge_in};
            rem_ff  <= {rem_in[REM_W-2:0], 1'b0};
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

@@ rtl/core/cspc_lerp.sv @@
// Attribute interpolator: registered magnitude product, then rounding and add.
module cspc_lerp (
   input  logic                         clock,
   input  logic [cspc_pkg::ATTR_W-1:0]  val_a,
   input  logic [cspc_pkg::ATTR_W-1:0]  val_b,
   input  logic [cspc_pkg::T_W-1:0]     frac,
   output logic [cspc_pkg::ATTR_W-1:0]  result
);
   import cspc_pkg::*;

   localparam int DW = ATTR_W + 1;
   localparam int PW = DW + T_W;
   localparam int SW = PW - FRAC_W;

   logic signed [DW-1:0] delta_in;
   logic [DW-1:0]        mag_in;
   logic [PW-1:0]        prod_ff;
   logic                 neg_ff;
   logic [ATTR_W-1:0]    base_ff;
   logic [PW-1:0]        round_in;
   logic [SW-1:0]        step_in;
   logic [DW-1:0]        sum_in;

   // stage one: |b - a| times the fraction
   always_comb begin
      delta_in = DW'($signed(val_b)) - DW'($signed(val_a));
      mag_in   = delta_in[DW-1] ? DW'(-delta_in) : DW'(delta_in);
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mag_in) * PW'(frac);
      neg_ff  <= delta_in[DW-1];
      base_ff <= val_a;
   end

   // stage two: round half away from zero and step from a towards b
   always_comb begin
      round_in = prod_ff + (PW'(1) << (FRAC_W - 1));
      step_in  = round_in[PW-1:FRAC_W];
      if (neg_ff) begin
         sum_in = DW'($signed(base_ff)) - DW'(step_in);
      end else begin
         sum_in = DW'($signed(base_ff)) + DW'(step_in);
      end
   end

   assign result = sum_in[ATTR_W-1:0];
endmodule

@@ rtl/core/clip_space_polygon_clipper_unit.sv @@
// Top level of the clip-space polygon clipper: vertex load, clip sequencer, emission.
//
// Vertices arrive on the req_ stream, one transfer per vertex, at one per cycle while
// the block is loading. req_tlast marks the final vertex and starts clipping; vertices
// beyond MAX_VERTS are dropped. The polygon is clipped against near, +x, -x, +y and -y
// in turn, the vertex set held in one RAM as two ping-pong banks of whole vertex words.
// Each pass edge is a RAM read, test and write; a crossing edge also runs the serial
// divider that forms the crossing fraction and the shared multiplier stepping through
// the eight attributes. The survivors then leave on the rsp_ stream, each read from
// the RAM into the output register, with rsp_tlast on the final one; nothing is sent
// if fewer than three vertices are loaded or survive a pass. req_tready is high only
// while loading, so a polygon occupies the block from its last vertex until its last
// result sits in the output register. A stalled receiver holds that register and
// pauses the emission. csr_ writes set the near-plane limit on w (Q16.16); the user
// must make them only while the block is idle; the block does not enforce this. Reset
// (sync, active high) empties the vertex count and the output register, restores the
// near limit to 0.05; the RAM contents need no clearing.
module clip_space_polygon_clipper_unit (
   input  logic                          clock,
   input  logic                          reset,
   // tdata: clip_x, clip_y, clip_w, world_x, world_y, world_z, tex_s, tex_t
   input  logic [cspc_pkg::VTX_W-1:0]    req_tdata,
   input  logic                          req_tlast,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: out_x, out_y, out_z, out_s, out_t
   output logic [cspc_pkg::OUT_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wr_en,
   input  logic [cspc_pkg::NEAR_W-1:0]   csr_wr_data
);
   import cspc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LD_FIRST,
      ST_EDGE_RD,
      ST_EDGE_LD,
      ST_EVAL,
      ST_CROSS,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_WR,
      ST_NEXT,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type            st_ff;
   logic [NEAR_W-1:0]    near_ff;
   logic [CNT_W-1:0]     vcnt_ff;
   logic                 bank_ff;
   plane_type            plane_ff;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [CNT_W-1:0]     on_ff;
   logic [KSEL_W-1:0]    k_ff;
   logic [VTX_W-1:0]     first_ff;
   logic [VTX_W-1:0]     a_ff;
   logic [VTX_W-1:0]     b_ff;
   logic [VTX_W-1:0]     res_ff;
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 req_xfer;
   logic [CNT_W-1:0]     vcnt_in;
   logic [CNT_W-1:0]     i_next_in;
   logic                 wrap_in;
   logic [ADDR_W-1:0]    src_base_in;
   logic [ADDR_W-1:0]    dst_base_in;
   logic signed [DIST_W-1:0] da_in;
   logic signed [DIST_W-1:0] db_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic [DIFF_W-1:0]    num_in;
   logic [DIFF_W-1:0]    den_in;
   logic                 ina_in;
   logic                 inb_in;
   logic                 out_free_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [VTX_W-1:0]     ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [VTX_W-1:0]     ram_rdata;

   logic                 div_start;
   logic                 div_done;
   logic [T_W-1:0]       div_quot;
   logic [ATTR_W-1:0]    lerp_out;

   // edge tests and bank addressing
   always_comb begin
      req_xfer    = req_tvalid && req_tready;
      vcnt_in     = (vcnt_ff < CNT_W'(MAX_VERTS)) ? vcnt_ff + 1'b1 : vcnt_ff;
      i_next_in   = i_ff + 1'b1;
      wrap_in     = (i_next_in == n_ff);
      src_base_in = bank_ff ? ADDR_W'(BANK) : '0;
      dst_base_in = bank_ff ? '0 : ADDR_W'(BANK);
      da_in       = plane_dist(plane_ff, a_ff, near_ff);
      db_in       = plane_dist(plane_ff, b_ff, near_ff);
      diff_in     = DIFF_W'(da_in) - DIFF_W'(db_in);
      num_in      = da_in[DIST_W-1] ? DIFF_W'(-da_in) : DIFF_W'(da_in);
      den_in      = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);
      ina_in      = !da_in[DIST_W-1];
      inb_in      = !db_in[DIST_W-1];
      out_free_in = !rsp_valid_ff || rsp_tready;
      div_start   = (st_ff == ST_CROSS) && (on_ff < CNT_W'(PASS_CAP));
   end

   // RAM port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = a_ff;
      ram_re    = 1'b0;
      ram_raddr = src_base_in;
      case (st_ff)
         ST_IDLE: begin
            ram_we    = req_xfer && (vcnt_ff < CNT_W'(MAX_VERTS));
            ram_waddr = ADDR_W'(vcnt_ff);
            ram_wdata = req_tdata;
         end
         ST_EVAL: begin
            ram_we    = ina_in && (on_ff < CNT_W'(PASS_CAP));
            ram_waddr = dst_base_in + ADDR_W'(on_ff);
         end
         ST_WR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_base_in + ADDR_W'(on_ff);
            ram_wdata = res_ff;
         end
         ST_START: begin
            ram_re = 1'b1;
         end
         ST_EDGE_RD: begin
            ram_re    = !wrap_in;
            ram_raddr = src_base_in + ADDR_W'(i_next_in);
         end
         ST_EMIT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = src_base_in + ADDR_W'(i_ff);
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   // sequencer with load, clip passes and emission
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         near_ff      <= NEAR_RESET;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            near_ff <= csr_wr_data;
         end
         // the emit state reloads the output register itself
         if (rsp_valid_ff && rsp_tready && (st_ff != ST_EMIT_LD)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_tlast) begin
                     vcnt_ff  <= '0;
                     n_ff     <= vcnt_in;
                     bank_ff  <= 1'b0;
                     plane_ff <= PLANE_NEAR;
                     i_ff     <= '0;
                     on_ff    <= '0;
                     if (vcnt_in >= CNT_W'(3)) begin
                        st_ff <= ST_START;
                     end
                  end else begin
                     vcnt_ff <= vcnt_in;
                  end
               end
            end
            ST_START: begin
               st_ff <= ST_LD_FIRST;
            end
            ST_LD_FIRST: begin
               first_ff <= ram_rdata;
               a_ff     <= ram_rdata;
               st_ff    <= ST_EDGE_RD;
            end
            ST_EDGE_RD: begin
               if (wrap_in) begin
                  b_ff  <= first_ff;
                  st_ff <= ST_EVAL;
               end else begin
                  st_ff <= ST_EDGE_LD;
               end
            end
            ST_EDGE_LD: begin
               b_ff  <= ram_rdata;
               st_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (ina_in && (on_ff >= CNT_W'(PASS_CAP))) begin
                  st_ff <= ST_PASS_END;
               end else begin
                  if (ina_in) begin
                     on_ff <= on_ff + 1'b1;
                  end
                  st_ff <= (ina_in != inb_in) ? ST_CROSS : ST_NEXT;
               end
            end
            ST_CROSS: begin
               st_ff <= div_start ? ST_DIV : ST_PASS_END;
            end
            ST_DIV: begin
               if (div_done) begin
                  k_ff  <= '0;
                  st_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               st_ff <= ST_ADD;
            end
            ST_ADD: begin
               res_ff[k_ff*ATTR_W +: ATTR_W] <= lerp_out;
               k_ff  <= k_ff + 1'b1;
               st_ff <= (k_ff == KSEL_W'(NUM_ATTR - 1)) ? ST_WR : ST_MUL;
            end
            ST_WR: begin
               on_ff <= on_ff + 1'b1;
               st_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               a_ff  <= b_ff;
               i_ff  <= i_next_in;
               st_ff <= wrap_in ? ST_PASS_END : ST_EDGE_RD;
            end
            ST_PASS_END: begin
               n_ff     <= on_ff;
               on_ff    <= '0;
               i_ff     <= '0;
               bank_ff  <= !bank_ff;
               plane_ff <= plane_type'(plane_ff + 3'd1);
               if (on_ff < CNT_W'(3)) begin
                  st_ff <= ST_IDLE;
               end else if (plane_ff == PLANE_YNEG) begin
                  st_ff <= ST_EMIT_RD;
               end else begin
                  st_ff <= ST_START;
               end
            end
            ST_EMIT_RD: begin
               st_ff <= ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
               if (out_free_in) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= ram_rdata[ATTR_EX*ATTR_W +: OUT_W];
                  rsp_last_ff  <= wrap_in;
                  i_ff         <= i_next_in;
                  st_ff        <= wrap_in ? ST_IDLE : ST_EMIT_RD;
               end
            end
            default: begin
               st_ff <= ST_IDLE;
            end
         endcase
      end
   end

   cspc_ram #(
      .WIDTH (VTX_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cspc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_in),
      .den   (den_in),
      .done  (div_done),
      .quot  (div_quot)
   );

   cspc_lerp u_lerp (
      .clock  (clock),
      .val_a  (a_ff[k_ff*ATTR_W +: ATTR_W]),
      .val_b  (b_ff[k_ff*ATTR_W +: ATTR_W]),
      .frac   (div_quot),
      .result (lerp_out)
   );

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

@@ tb/tb_clip_space_polygon_clipper_unit.sv @@
// Self-checking testbench of the clip-space polygon clipper: random polygons, stalls, CSR phases.
module tb_clip_space_polygon_clipper_unit;
   import cspc_pkg::*;

   typedef struct {
      logic signed [31:0] a [8];   // cx, cy, cw, ex, ey, ez, s, t
      logic               last;
   } vertex_type;

   typedef struct {
      logic [OUT_W-1:0] data;
      logic             last;
   } clipped_vtx_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [VTX_W-1:0]    req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [OUT_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_wr_en = 1'b0;
   logic [NEAR_W-1:0]   csr_wr_data = '0;

   clip_space_polygon_clipper_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] loaded [MAX_VERTS][8];
   int                 loaded_cnt = 0;
   logic [NEAR_W-1:0]  near_limit = NEAR_RESET;

   vertex_type      pending_vtx [$];
   clipped_vtx_type expected_vtx [$];
   int              error_cnt = 0;
   int              idle_cycles = 0;

   function automatic logic signed [63:0] dist_of(int p, logic signed [31:0] v [8]);
      logic signed [63:0] x, y, w;
      x = v[0]; y = v[1]; w = v[2];
      case (p)
         PLANE_NEAR: return w - $signed({47'd0, near_limit});
         PLANE_XPOS: return w - x;
         PLANE_XNEG: return w + x;
         PLANE_YPOS: return w - y;
         default:    return w + y;
      endcase
   endfunction

   function automatic logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Sutherland-Hodgman clip of the loaded polygon, pushes surviving vertices
   task automatic clip_polygon(int n);
      logic signed [31:0] src [PASS_CAP][8];
      logic signed [31:0] dst [PASS_CAP][8];
      logic signed [63:0] da, db, a, delta;
      logic [63:0]        num, den, t30, stp;
      logic [127:0]       prod;
      clipped_vtx_type    cv;
      int                 cnt, on, ib;
      cnt = n;
      for (int i = 0; i < n; i++) src[i] = loaded[i];
      for (int p = 0; p < 5; p++) begin
         on = 0;
         for (int i = 0; i < cnt; i++) begin
            ib = (i + 1 == cnt) ? 0 : i + 1;
            da = dist_of(p, src[i]);
            db = dist_of(p, src[ib]);
            if (da >= 0) begin
               if (on >= PASS_CAP) break;
               dst[on] = src[i];
               on++;
            end
            if ((da >= 0) != (db >= 0)) begin
               if (on >= PASS_CAP) break;
               num = mag(da);
               den = mag(da - db);
               t30 = (num << 30) / den;
               for (int k = 0; k < 8; k++) begin
                  a = src[i][k];
                  delta = 64'(src[ib][k]) - a;
                  prod = 128'(mag(delta)) * 128'(t30) + (128'd1 << 29);
                  stp = 64'(prod >> 30);
                  dst[on][k] = 32'(delta < 0 ? a - $signed(stp) : a + $signed(stp));
               end
               on++;
            end
         end
         cnt = on;
         if (cnt < 3) return;
         for (int i = 0; i < cnt; i++) src[i] = dst[i];
      end
      for (int i = 0; i < cnt; i++) begin
         cv.data = {src[i][7], src[i][6], src[i][5], src[i][4], src[i][3]};
         cv.last = (i + 1 == cnt);
         expected_vtx.push_back(cv);
      end
   endtask

   task automatic predict_vertex(vertex_type v);
      if (loaded_cnt < MAX_VERTS) begin
         loaded[loaded_cnt] = v.a;
         loaded_cnt++;
      end
      if (v.last) begin
         if (loaded_cnt >= 3) clip_polygon(loaded_cnt);
         loaded_cnt = 0;
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   int  send_gap = 0;
   bit  burst_mode = 0;
   always @(posedge clock) begin
      vertex_type v;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_vertex(pending_vtx.pop_front());
            send_gap = burst_mode ? 0 : gap_len();
         end
         else if (!req_tvalid && send_gap > 0) send_gap--;
         if ((req_tvalid && !req_tready) || send_gap > 0 ||
             pending_vtx.size() == 0) begin
            if (!(req_tvalid && !req_tready)) req_tvalid <= 1'b0;
         end
         else begin
            v = pending_vtx[0];
            req_tdata  <= {v.a[7], v.a[6], v.a[5], v.a[4], v.a[3], v.a[2], v.a[1], v.a[0]};
            req_tlast  <= v.last;
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      clipped_vtx_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vtx.size() == 0) begin
               $display("%0t: unexpected vertex %h last %b", $time, rsp_tdata, rsp_tlast);
               error_cnt++;
            end
            else begin
               e = expected_vtx.pop_front();
               for (int f = 0; f < 5; f++)
                  if (rsp_tdata[f*32 +: 32] !== e.data[f*32 +: 32]) begin
                     $display("%0t: field %0d expected %h actual %h", $time, f,
                              e.data[f*32 +: 32], rsp_tdata[f*32 +: 32]);
                     error_cnt++;
                  end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: last expected %b actual %b", $time, e.last, rsp_tlast);
                  error_cnt++;
               end
            end
            recv_gap = burst_mode ? 0 : gap_len();
         end
         else if (recv_gap > 0) recv_gap--;
         rsp_tready <= (recv_gap == 0);
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 100000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] rnd_any();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   // queue one vertex with the given clip x, y, w and random remaining attributes
   task automatic add_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] w, bit last);
      vertex_type v;
      v.a[0] = x; v.a[1] = y; v.a[2] = w;
      for (int k = 3; k < 8; k++) v.a[k] = $urandom;
      v.last = last;
      pending_vtx.push_back(v);
   endtask

   task automatic add_random_polygon(int n);
      int r;
      logic signed [31:0] w;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_vertex(rnd_any(), rnd_any(), rnd_any(), i == n - 1);
         else begin
            w = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0001_0000;
            r = $urandom_range(0, 32'h0010_0000);
            add_vertex($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                       $signed(r) - 32'sh0008_0000, w, i == n - 1);
         end
      end
   endtask

   // sender pauses here until every result is in and the block is idle again
   task automatic wait_drained();
      while (pending_vtx.size() != 0 || req_tvalid || expected_vtx.size() != 0 ||
             !req_tready)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_near(logic [NEAR_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      near_limit = val;
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: square fully inside, square straddling all planes, degenerate cases
      add_vertex(-32'sh8000, -32'sh8000, 32'sh10000, 0);
      add_vertex(32'sh8000, -32'sh8000, 32'sh10000, 0);
      add_vertex(32'sh8000, 32'sh8000, 32'sh10000, 0);
      add_vertex(-32'sh8000, 32'sh8000, 32'sh10000, 1);
      add_vertex(-32'sh20000, -32'sh20000, 32'sh10000, 0);
      add_vertex(32'sh20000, -32'sh20000, 32'sh10000, 0);
      add_vertex(32'sh20000, 32'sh20000, -32'sh100, 0);
      add_vertex(-32'sh20000, 32'sh20000, 32'sh10000, 1);
      add_vertex(0, 0, 32'sh10000, 0);          // too few vertices
      add_vertex(0, 0, 32'sh10000, 1);
      add_vertex(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
      add_vertex(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0);
      add_vertex(0, 0, 32'sh7fff_ffff, 1);
      for (int i = 0; i < 36; i++)            // too many vertices, dropped
         add_vertex(0, 0, 32'sh10000 + i, i == 35);
      wait_drained();

      // register phases including extremes and out-of-range values
      write_near(17'd1);
      add_random_polygon(5);
      add_random_polygon(3);
      wait_drained();
      write_near(17'd65536);
      add_random_polygon(4);
      wait_drained();
      write_near(17'd0);
      add_random_polygon(6);
      wait_drained();
      write_near(17'h1ffff);
      add_random_polygon(4);
      wait_drained();
      write_near(NEAR_RESET);

      // random polygons, one burst stretch without gaps
      sent = 0;
      while (sent < 40) begin
         int n;
         n = $urandom_range(0, 19) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
         add_random_polygon(n);
         sent += n;
         if (sent > 15 && sent < 25) burst_mode = 1;
         else burst_mode = 0;
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
            write_near(NEAR_W'($urandom_range(1, 65536)));
         end
      end
      burst_mode = 0;
      wait_drained();
      if (error_cnt == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/cspc_pkg.sv
rtl/core/cspc_ram.sv
rtl/core/cspc_div.sv
rtl/core/cspc_lerp.sv
rtl/core/clip_space_polygon_clipper_unit.sv
tb/tb_clip_space_polygon_clipper_unit.sv
